// File: sv/assert_macros.svh
// Assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: sv/lop_pkg.sv
// Package for the lifetime offset planner: types, sizes and constants
`timescale 1ns / 1ps
package lop_pkg;
    localparam int MaxIntervals = 256;
    localparam int ElemBytes = 4;
    localparam int TimeBits = 16;
    localparam int IdxBits = $clog2(MaxIntervals);
    localparam int CntBits = $clog2(MaxIntervals + 1);
    localparam logic [39:0] Max40 = {40{1'b1}};

    typedef struct packed {
        logic        first_of_plan;
        logic [15:0] start_step;
        logic [15:0] finish_step;
        logic [31:0] element_count;
    } req_t;

    typedef struct packed {
        logic [39:0] placed_offset;
        logic [32:0] padded_count;
        logic [39:0] pool_elements;
        logic        stored;
        logic        table_full;
    } res_t;

    typedef struct packed {
        logic [TimeBits-1:0] start_step;
        logic [TimeBits-1:0] finish_step;
        logic [39:0]         offset;
        logic [39:0]         upper;
    } entry_t;
endpackage

// File: sv/lifetime_offset_planner.sv
// Top level of the lifetime offset planner
`timescale 1ns / 1ps
// Sequence: the byte count is padded bit-serially, then stored entries are scanned for a gap,
// the insert position is sought and the entries above it are shifted up before the insert;
// a zero count skips the padding and the search, and a full table skips the search.
// One request at a time (busy high); the next request can be taken in the strobe cycle.
// The result strobe is high for one cycle; the receiver cannot stall.
// Reset clears the table count, pool size and alignment (to 64); table memory is not cleared.
module lifetime_offset_planner (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  lop_pkg::req_t  req,
    output logic           res_valid,
    output lop_pkg::res_t  res,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [12:0]    cfg_data
);
    logic [12:0] align_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            align_reg <= 13'd64;
        end
        else if (cfg_valid && cfg_ready)
        begin
            align_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    lop_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .req(req), .align(align_reg),
        .busy(busy), .done(res_valid), .res(res)
    );
endmodule

// File: sv/lop_entry_ram.sv
// Placement table: one write port and one registered read port
`timescale 1ns / 1ps
module lop_entry_ram (
    input  logic                         clk,
    input  logic                         we,
    input  logic [lop_pkg::IdxBits-1:0]  waddr,
    input  lop_pkg::entry_t              wdata,
    input  logic [lop_pkg::IdxBits-1:0]  raddr,
    output lop_pkg::entry_t              rdata
);
    lop_pkg::entry_t mem [lop_pkg::MaxIntervals];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/lop_pad_unit.sv
// Alignment padding: bit-serial remainder of the byte count by align (zero taken as one)
`timescale 1ns / 1ps
module lop_pad_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [31:0] count,
    input  logic [12:0] align,
    output logic        done,
    output logic [32:0] padded
);
    localparam int BBits = 35;
    localparam logic [BBits-1:0] ElemBytesC = BBits'(lop_pkg::ElemBytes);

    logic [BBits-1:0] bytes_reg, bytes_next;
    logic [12:0]      rem_reg, rem_next;
    logic [12:0]      a_reg, a_next;
    logic [5:0]       bit_reg, bit_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [32:0]      pad_reg, pad_next;
    logic [13:0]      trial;

    always_comb
    begin
        bytes_next = bytes_reg;
        rem_next = rem_reg;
        a_next = a_reg;
        bit_next = bit_reg;
        run_next = run_reg;
        done_next = 1'b0;
        pad_next = pad_reg;
        trial = {rem_reg, bytes_reg[bit_reg[5:0]]};
        if (go)
        begin
            bytes_next = BBits'({3'b0, count} * ElemBytesC);
            a_next = (align == 13'd0) ? 13'd1 : align;
            rem_next = '0;
            bit_next = 6'(BBits - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = (trial >= {1'b0, a_reg}) ? 13'(trial - {1'b0, a_reg}) : trial[12:0];
            if (bit_reg == 6'd0)
            begin
                run_next = 1'b0;
                done_next = 1'b1;
                if (rem_next == 13'd0)
                begin
                    pad_next = 33'(bytes_reg / lop_pkg::ElemBytes);
                end
                else
                begin
                    pad_next = 33'(({1'b0, bytes_reg} + {{(BBits-12){1'b0}}, a_reg}
                        - {{(BBits-12){1'b0}}, rem_next}) / lop_pkg::ElemBytes);
                end
            end
            else
            begin
                bit_next = bit_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
        rem_reg <= rem_next;
        a_reg <= a_next;
        bit_reg <= bit_next;
        pad_reg <= pad_next;
    end

    assign done = done_reg;
    assign padded = pad_reg;
endmodule

// File: sv/lop_ctrl.sv
// Sequencer: scan the table for a gap, then shift and insert the placement
`timescale 1ns / 1ps
module lop_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  lop_pkg::req_t                req,
    input  logic [12:0]                  align,
    output logic                         busy,
    output logic                         done,
    output lop_pkg::res_t                res
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PAD   = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_SEEK  = 7'b0001000,
        S_SHIFT = 7'b0010000,
        S_PUT   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [lop_pkg::CntBits-1:0] total_reg, total_next;
    logic [lop_pkg::CntBits-1:0] i_reg, i_next;
    logic [lop_pkg::CntBits-1:0] pos_reg, pos_next;
    logic [39:0] pool_reg, pool_next;
    logic [39:0] cur_reg, cur_next;
    logic [39:0] up_reg, up_next;
    logic        stop_reg, stop_next;
    logic        wait_reg, wait_next;
    lop_pkg::req_t req_reg, req_next;
    lop_pkg::res_t res_reg, res_next;
    logic        done_reg, done_next;
    logic        pad_go, pad_done;
    logic [32:0] padded;
    logic [32:0] size_reg, size_next;

    logic        we;
    logic [lop_pkg::IdxBits-1:0] waddr, raddr;
    lop_pkg::entry_t wdata, rdata;
    logic [40:0] cand;
    logic [40:0] upsum;

    lop_pad_unit u_pad (
        .clk(clk), .rst_n(rst_n), .go(pad_go), .count(req_reg.element_count),
        .align(align), .done(pad_done), .padded(padded)
    );

    lop_entry_ram u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    assign cand = {1'b0, cur_reg} + {8'b0, size_reg};
    assign upsum = {1'b0, cur_reg} + {8'b0, size_reg};

    always_comb
    begin
        state_next = state_reg;
        total_next = total_reg;
        i_next = i_reg;
        pos_next = pos_reg;
        pool_next = pool_reg;
        cur_next = cur_reg;
        up_next = up_reg;
        stop_next = stop_reg;
        wait_next = 1'b0;
        req_next = req_reg;
        res_next = res_reg;
        done_next = 1'b0;
        size_next = size_reg;
        pad_go = 1'b0;
        we = 1'b0;
        waddr = i_reg[lop_pkg::IdxBits-1:0];
        wdata = rdata;
        raddr = i_reg[lop_pkg::IdxBits-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    req_next.start_step = 16'(req.start_step[lop_pkg::TimeBits-1:0]);
                    req_next.finish_step = 16'(req.finish_step[lop_pkg::TimeBits-1:0]);
                    if (req.first_of_plan)
                    begin
                        total_next = '0;
                        pool_next = '0;
                    end
                    state_next = S_PAD;
                    wait_next = 1'b1;
                end
            end
            S_PAD:
            begin
                pad_go = wait_reg;
                if (req_reg.element_count == 32'd0)
                begin
                    res_next = '{placed_offset: '0, padded_count: '0,
                                 pool_elements: pool_reg, stored: 1'b0, table_full: 1'b0};
                    state_next = S_OUT;
                end
                // ignore a done left over from an earlier zero-count request
                else if (pad_done && !wait_reg)
                begin
                    size_next = padded;
                    if (total_reg == lop_pkg::CntBits'(lop_pkg::MaxIntervals))
                    begin
                        res_next = '{placed_offset: '0, padded_count: padded,
                                     pool_elements: pool_reg, stored: 1'b0, table_full: 1'b1};
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cur_next = '0;
                        stop_next = 1'b0;
                        i_next = '0;
                        raddr = '0;
                        wait_next = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // each entry is addressed, then evaluated from the registered data
                if (i_reg >= total_reg || stop_reg)
                begin
                    up_next = upsum[40] ? lop_pkg::Max40 : upsum[39:0];
                    i_next = '0;
                    wait_next = 1'b1;
                    state_next = S_SEEK;
                end
                else if (wait_reg)
                begin
                    raddr = i_reg[lop_pkg::IdxBits-1:0];
                end
                else
                begin
                    if (req_reg.start_step[lop_pkg::TimeBits-1:0] <= rdata.finish_step
                        && req_reg.finish_step[lop_pkg::TimeBits-1:0] >= rdata.start_step)
                    begin
                        if (cand <= {1'b0, rdata.offset})
                        begin
                            stop_next = 1'b1;
                        end
                        else if (rdata.upper > cur_reg)
                        begin
                            cur_next = rdata.upper;
                        end
                    end
                    i_next = i_reg + 1'b1;
                    raddr = i_next[lop_pkg::IdxBits-1:0];
                    wait_next = 1'b1;
                end
            end
            S_SEEK:
            begin
                if (up_reg > pool_reg)
                begin
                    pool_next = up_reg;
                end
                if (i_reg >= total_reg)
                begin
                    pos_next = i_reg;
                    i_next = total_reg;
                    wait_next = 1'b1;
                    state_next = S_SHIFT;
                end
                else if (wait_reg)
                begin
                    raddr = i_reg[lop_pkg::IdxBits-1:0];
                end
                else if (rdata.offset < cur_reg)
                begin
                    i_next = i_reg + 1'b1;
                    raddr = i_next[lop_pkg::IdxBits-1:0];
                    wait_next = 1'b1;
                end
                else
                begin
                    pos_next = i_reg;
                    i_next = total_reg;
                    wait_next = 1'b1;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                // move entry i-1 up to i, top down
                raddr = lop_pkg::IdxBits'(i_reg - 1'b1);
                if (i_reg == pos_reg)
                begin
                    state_next = S_PUT;
                end
                else if (wait_reg)
                begin
                    raddr = lop_pkg::IdxBits'(i_reg - 1'b1);
                end
                else
                begin
                    we = 1'b1;
                    waddr = i_reg[lop_pkg::IdxBits-1:0];
                    wdata = rdata;
                    i_next = i_reg - 1'b1;
                    raddr = lop_pkg::IdxBits'(i_next - 1'b1);
                    wait_next = 1'b1;
                end
            end
            S_PUT:
            begin
                we = 1'b1;
                waddr = pos_reg[lop_pkg::IdxBits-1:0];
                wdata = '{start_step: req_reg.start_step[lop_pkg::TimeBits-1:0],
                          finish_step: req_reg.finish_step[lop_pkg::TimeBits-1:0],
                          offset: cur_reg, upper: up_reg};
                total_next = total_reg + 1'b1;
                res_next = '{placed_offset: cur_reg, padded_count: size_reg,
                             pool_elements: pool_reg, stored: 1'b1, table_full: 1'b0};
                state_next = S_OUT;
            end
            S_OUT:
            begin
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            pool_reg <= '0;
            done_reg <= 1'b0;
            wait_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            pool_reg <= pool_next;
            done_reg <= done_next;
            wait_reg <= wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        pos_reg <= pos_next;
        cur_reg <= cur_next;
        up_reg <= up_next;
        stop_reg <= stop_next;
        req_reg <= req_next;
        res_reg <= res_next;
        size_reg <= size_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign res = res_reg;
endmodule

// File: sv/lop_checker.sv
// Port-level checker for the lifetime offset planner, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lop_port_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          res_valid,
    input lop_pkg::res_t res
);
    `CHK_NEXT(a_take_busy, clk, rst_n, start && !busy, busy, "request not taken")
    `CHK_IMPLY(a_one_flag, clk, rst_n, res_valid, !(res.stored && res.table_full), "both flags")
    `CHK_IMPLY(a_full_zero, clk, rst_n, res_valid && !res.stored, res.placed_offset == 40'd0, "offset")
    `CHK_IMPLY(a_pool_cover, clk, rst_n, res_valid && res.stored, res.pool_elements >= res.placed_offset, "pool")
endmodule

bind lifetime_offset_planner lop_port_checker u_lop_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .res_valid(res_valid), .res(res)
);

// File: tb/lop_checker.sv
// Checker for the lifetime offset planner: predicts each placement and compares results
`timescale 1ns / 1ps
module lop_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  lop_pkg::req_t  req,
    input  logic           res_valid,
    input  lop_pkg::res_t  res,
    input  logic           cfg_valid,
    input  logic           cfg_ready,
    input  logic [12:0]    cfg_data,
    output int             fail_count,
    output int             pending
);
    logic [12:0]       align_now;
    lop_pkg::entry_t   plan_tab [lop_pkg::MaxIntervals];
    int                plan_total;
    logic [39:0]       pool_size;
    lop_pkg::res_t     placements_due [$];
    int                fails;

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fails++;
    endtask

    // Greedy placement by offset; updates the plan table as the block would
    function automatic lop_pkg::res_t plan_placement(lop_pkg::req_t r);
        lop_pkg::res_t o;
        logic [63:0]   a, bytes, size, cur, upper;
        int            i, pos;
        logic [15:0]   s, f;
        s = r.start_step;
        f = r.finish_step;
        o = '0;
        if (r.first_of_plan)
        begin
            plan_total = 0;
            pool_size = '0;
        end
        if (r.element_count == 0)
        begin
            o.pool_elements = pool_size;
            return o;
        end
        a = (align_now == 0) ? 64'd1 : 64'(align_now);
        bytes = 64'(r.element_count) * lop_pkg::ElemBytes;
        bytes += (a - bytes % a) % a;
        size = (bytes / lop_pkg::ElemBytes) & 64'h1_FFFF_FFFF;
        o.padded_count = size[32:0];
        if (plan_total >= lop_pkg::MaxIntervals)
        begin
            o.pool_elements = pool_size;
            o.table_full = 1'b1;
            return o;
        end
        cur = 0;
        for (i = 0; i < plan_total; i++)
        begin
            if (s <= plan_tab[i].finish_step && f >= plan_tab[i].start_step)
            begin
                if (cur + size <= 64'(plan_tab[i].offset))
                    break;
                if (64'(plan_tab[i].upper) > cur)
                    cur = 64'(plan_tab[i].upper);
            end
        end
        upper = cur + size;
        if (upper > 64'(lop_pkg::Max40))
            upper = 64'(lop_pkg::Max40);
        if (upper[39:0] > pool_size)
            pool_size = upper[39:0];
        pos = 0;
        while (pos < plan_total && 64'(plan_tab[pos].offset) < cur)
            pos++;
        for (i = plan_total; i > pos; i--)
            plan_tab[i] = plan_tab[i-1];
        plan_tab[pos] = '{start_step: s, finish_step: f, offset: cur[39:0], upper: upper[39:0]};
        plan_total++;
        o.placed_offset = cur[39:0];
        o.pool_elements = pool_size;
        o.stored = 1'b1;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            align_now = 13'd64;
            plan_total = 0;
            pool_size = '0;
            fails = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            lop_pkg::res_t want;
            if (cfg_valid && cfg_ready)
                align_now = cfg_data;
            if (res_valid)
            begin
                if (placements_due.size() == 0)
                    report("unexpected result", 64'(res.placed_offset), 64'd0);
                else
                begin
                    want = placements_due.pop_front();
                    if (res.placed_offset !== want.placed_offset)
                        report("placed_offset", 64'(res.placed_offset),
                               64'(want.placed_offset));
                    if (res.padded_count !== want.padded_count)
                        report("padded_count", 64'(res.padded_count), 64'(want.padded_count));
                    if (res.pool_elements !== want.pool_elements)
                        report("pool_elements", 64'(res.pool_elements),
                               64'(want.pool_elements));
                    if (res.stored !== want.stored)
                        report("stored", 64'(res.stored), 64'(want.stored));
                    if (res.table_full !== want.table_full)
                        report("table_full", 64'(res.table_full), 64'(want.table_full));
                end
            end
            if (start && !busy)
                placements_due.push_back(plan_placement(req));
            fail_count <= fails;
            pending <= placements_due.size();
        end
    end
endmodule

// File: tb/tb_lifetime_offset_planner.sv
// Testbench top for the lifetime offset planner: stimulus, configuration and verdict
`timescale 1ns / 1ps
module tb_lifetime_offset_planner;
    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    lop_pkg::req_t req;
    logic          res_valid;
    lop_pkg::res_t res;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [12:0]   cfg_data;
    int            fail_count;
    int            pending;
    int            idle_pct;

    lifetime_offset_planner dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .res_valid(res_valid), .res(res),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    lop_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .res_valid(res_valid), .res(res),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    task automatic place(logic first, logic [15:0] s, logic [15:0] f, logic [31:0] cnt);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req <= '{first_of_plan: first, start_step: s, finish_step: f, element_count: cnt};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drain all outstanding requests before touching the register
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_align(logic [12:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        logic        first;
        logic [15:0] s, f, t;
        logic [31:0] cnt;
        int          pick;
        first = ($urandom_range(11) == 0);
        pick = $urandom_range(9);
        if (pick == 0)
        begin
            s = 16'($urandom());
            f = 16'($urandom());
        end
        else
        begin
            s = 16'($urandom_range(60));
            f = 16'(s + $urandom_range(15));
            if (pick == 1)
            begin
                t = s;
                s = f;
                f = t;
            end
        end
        pick = $urandom_range(19);
        if (pick == 0)
            cnt = 0;
        else if (pick == 1)
            cnt = $urandom();
        else
            cnt = $urandom_range(1, 2000);
        place(first, s, f, cnt);
    endtask

    initial
    begin
        logic [12:0] aligns [6];
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        idle_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset alignment, zero count, gaps, reversed lifetime, extremes
        place(1'b1, 16'd0, 16'd10, 32'd0);
        place(1'b0, 16'd0, 16'd10, 32'd1);
        place(1'b0, 16'd5, 16'd15, 32'd100);
        place(1'b0, 16'd20, 16'd30, 32'd7);
        place(1'b0, 16'd12, 16'd25, 32'd16);
        place(1'b0, 16'd30, 16'd5, 32'd9);
        place(1'b0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        place(1'b0, 16'd0, 16'hFFFF, 32'd1);
        place(1'b0, 16'd3, 16'd3, 32'd0);
        write_align(13'd0);
        place(1'b1, 16'd1, 16'd2, 32'd5);
        place(1'b0, 16'd2, 16'd4, 32'd3);
        write_align(13'd3);
        place(1'b0, 16'd0, 16'd9, 32'd5);
        write_align(13'd1);
        place(1'b0, 16'd0, 16'd9, 32'hFFFF_FFFF);

        // Fill the table with overlapping maximal buffers to saturate the pool size
        write_align(13'd4096);
        place(1'b1, 16'd0, 16'hFFFF, 32'hFFFF_FFFF);
        for (int i = 1; i < lop_pkg::MaxIntervals; i++)
            place(1'b0, 16'd0, 16'hFFFF, 32'hFFFF_FFFF);
        place(1'b0, 16'd7, 16'd8, 32'd12);
        place(1'b0, 16'd7, 16'd8, 32'd0);

        aligns = '{13'd1, 13'd4096, 13'd64, 13'd4, 13'd0, 13'd1};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_align(ph == 5 ? 13'($urandom_range(1, 4096)) : aligns[ph]);
            idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 88 : 19);
            for (int n = 0; n < 150; n++)
                random_item();
        end
        idle_pct = 0;
        settle();

        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
